// File: src/cxf_pkg.sv
// shared types and constants for the clipped xor-fill edge setup block
package cxf_pkg;

  localparam int CW = 16;
  localparam int DIV_STEPS = 31;
  localparam int DIV_CW = $clog2(DIV_STEPS + 1);

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_RESET = 1'b1;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_FIX = 1'b1;

  localparam logic [1:0] OCT_4 = 2'd0;
  localparam logic [1:0] OCT_5 = 2'd1;
  localparam logic [1:0] OCT_6 = 2'd2;
  localparam logic [1:0] OCT_7 = 2'd3;

  typedef struct packed {
    logic                 op;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
  } item_t;

  typedef struct packed {
    logic                 kind;
    logic [CW-1:0]        start_x;
    logic [CW-1:0]        start_y;
    logic [1:0]           octant;
    logic                 sign_init;
    logic signed [CW-1:0] err_init;
    logic signed [CW-1:0] a_mod;
    logic [14:0]          b_mod;
    logic [9:0]           run_length;
    logic signed [CW-1:0] seed_low;
    logic signed [CW-1:0] seed_high;
  } desc_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TOP, S_BOT, S_XSW, S_LEFT, S_RIGHT,
    S_MUL, S_DST, S_DWT, S_LINE, S_LSET, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    CR_TOP, CR_BOT, CR_LEFT, CR_RIGHT
  } cross_t;

endpackage

// File: src/cxf_front.sv
// input side: accepts items, orders endpoints by y and queues them
module cxf_front import cxf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic signed [CW-1:0] in_ax,
  input  logic signed [CW-1:0] in_ay,
  input  logic signed [CW-1:0] in_bx,
  input  logic signed [CW-1:0] in_by,
  output logic                 q_valid,
  output item_t                q_item,
  input  logic                 q_pop
);

  item_t      mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      cls;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rptr_r];

  // put the upper endpoint first
  always_comb begin
    cls.op = in_op;
    if (in_ay > in_by) begin
      cls.x0 = in_bx;
      cls.y0 = in_by;
      cls.x1 = in_ax;
      cls.y1 = in_ay;
    end else begin
      cls.x0 = in_ax;
      cls.y0 = in_ay;
      cls.x1 = in_bx;
      cls.y1 = in_by;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (q_pop) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// File: src/cxf_div.sv
// shared iterative signed divider, one quotient bit per cycle, low 16 bits out
module cxf_div import cxf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [2*CW-1:0] num,
  input  logic signed [CW-1:0]   den,
  output logic                   done,
  output logic signed [CW-1:0]   quot
);

  logic              busy_r, done_r, neg_r, dz_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [CW-1:0]     rem_r, dv_r;
  logic [30:0]       qd_r;
  logic [2*CW-1:0]   mag_n;
  logic [CW:0]       shifted, trial;
  logic              qbit;
  logic [30:0]       qnew;
  logic signed [CW-1:0] quot_r;

  assign mag_n = num[2*CW-1] ? (2*CW)'(-num) : num;
  assign shifted = {rem_r, qd_r[30]};
  assign trial = shifted - {1'b0, dv_r};
  assign qbit = !trial[CW];
  assign qnew = {qd_r[29:0], qbit};
  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[2*CW-1] ^ den[CW-1];
      dz_r <= (den == '0);
      dv_r <= den[CW-1] ? CW'(-den) : den;
      rem_r <= '0;
      qd_r <= mag_n[30:0];
    end else if (busy_r) begin
      rem_r <= qbit ? trial[CW-1:0] : shifted[CW-1:0];
      qd_r <= qnew;
      if (cnt_r == DIV_CW'(1)) begin
        if (dz_r) quot_r <= '0;
        else if (neg_r) quot_r <= CW'(-qnew[CW-1:0]);
        else quot_r <= qnew[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= DIV_CW'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CW'(1);
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/cxf_back.sv
// work side: clip sequencer, fixup and line setup, span tracking, result register
module cxf_back import cxf_pkg::*; #(
  parameter int X_LIMIT = 319,
  parameter int Y_LIMIT = 199
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output desc_t out_desc,
  output logic  out_last
);

  localparam logic signed [CW-1:0] XL = CW'(X_LIMIT);
  localparam logic signed [CW-1:0] YL = CW'(Y_LIMIT);

  state_t state_r, state_nxt;
  cross_t cross_r;
  logic signed [CW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [2:0]           outside_r;
  logic                 hit_r;
  logic signed [CW-1:0] c_r, n_r, d_r;
  logic signed [2*CW-1:0] prod_r;
  logic signed [CW-1:0] span_lo_r, span_hi_r;
  desc_t                desc_r [2];
  logic [1:0]           cnt_r;
  logic                 idx_r;
  logic [CW-1:0]        lx_r, ly_r, sd_r;
  logic signed [CW-1:0] ed_r;
  logic                 out_valid_r, out_last_r;
  desc_t                out_desc_r;

  logic div_start, div_done;
  logic signed [CW-1:0] q;
  logic ld;

  cxf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (prod_r),
    .den  (d_r),
    .done (div_done),
    .quot (q)
  );

  // crossing results
  logic signed [CW-1:0] v_top, v_bot, v_left, v_right;
  assign v_top = x0_r - q;
  assign v_bot = x1_r + q;
  assign v_left = y0_r - q;
  assign v_right = y1_r + q;

  // fixup run
  logic signed [CW-1:0] fa, fb, f_lo, f_hi, c_lo, c_hi, rows, f_nlo, f_nhi;
  logic f_ok;
  desc_t f_desc;
  always_comb begin
    if (state_r == S_RIGHT) begin
      fa = y0_r;
      fb = y1_r;
    end else begin
      fa = y1_r;
      fb = v_right;
    end
    f_lo = (fa > fb) ? fb : fa;
    f_hi = (fa > fb) ? fa : fb;
    c_lo = (f_lo < 0) ? '0 : f_lo;
    c_hi = (f_hi > YL) ? YL : f_hi;
    f_ok = !(f_hi < 0 || f_lo > YL) && (c_hi != c_lo);
    rows = c_hi - c_lo;
    f_nlo = (c_lo < span_lo_r) ? c_lo : span_lo_r;
    f_nhi = (c_hi > span_hi_r) ? c_hi : span_hi_r;
    f_desc.kind = KIND_FIX;
    f_desc.start_x = XL;
    f_desc.start_y = c_lo;
    f_desc.octant = OCT_6;
    f_desc.err_init = CW'(-(rows <<< 1));
    f_desc.sign_init = f_desc.err_init[CW-1];
    f_desc.a_mod = CW'(-(rows <<< 2));
    f_desc.b_mod = '0;
    f_desc.run_length = rows[9:0];
    f_desc.seed_low = f_nlo;
    f_desc.seed_high = f_nhi;
  end

  // line endpoints as unsigned, ordered by row
  logic [CW-1:0] ux0, uy0, ux1, uy1;
  logic signed [CW-1:0] l_ed, l_nlo, l_nhi;
  logic [CW-1:0] l_sd;
  logic l_ok;
  always_comb begin
    if ($unsigned(y0_r) > $unsigned(y1_r)) begin
      ux0 = x1_r; uy0 = y1_r; ux1 = x0_r; uy1 = y0_r;
    end else begin
      ux0 = x0_r; uy0 = y0_r; ux1 = x1_r; uy1 = y1_r;
    end
    l_ed = ux1 - ux0;
    l_sd = uy1 - uy0;
    l_nlo = ($signed(uy0) < span_lo_r) ? $signed(uy0) : span_lo_r;
    l_nhi = ($signed(uy1) > span_hi_r) ? $signed(uy1) : span_hi_r;
    l_ok = !(l_ed > XL || l_ed < -XL || l_sd > $unsigned(YL));
  end

  // octant and error terms
  logic signed [CW:0] ed17, sd17;
  logic signed [CW-1:0] maj, mnr, bm, am;
  logic [1:0] oct;
  desc_t l_desc;
  always_comb begin
    ed17 = {ed_r[CW-1], ed_r};
    sd17 = {1'b0, sd_r};
    if (ed17 + sd17 < 0) begin
      maj = -ed_r; mnr = sd_r; oct = OCT_4;
    end else if (ed17 - sd17 < 0) begin
      maj = sd_r;
      if (ed_r < 0) begin
        mnr = -ed_r; oct = OCT_5;
      end else begin
        mnr = ed_r; oct = OCT_6;
      end
    end else begin
      maj = ed_r; mnr = sd_r; oct = OCT_7;
    end
    bm = mnr <<< 2;
    am = bm - (maj <<< 2);
    l_desc.kind = KIND_LINE;
    l_desc.start_x = lx_r;
    l_desc.start_y = ly_r;
    l_desc.octant = oct;
    l_desc.sign_init = am[CW-1];
    l_desc.err_init = am;
    l_desc.a_mod = am;
    l_desc.b_mod = bm[14:0];
    l_desc.run_length = maj[9:0];
    l_desc.seed_low = span_lo_r;
    l_desc.seed_high = span_hi_r;
  end

  assign ld = (state_r == S_OUT) && (cnt_r != 2'd0) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid && q_item.op == OP_EDGE) state_nxt = S_TOP;
      S_TOP: begin
        if (y1_r < 0) state_nxt = S_IDLE;
        else if (y0_r < 0) state_nxt = S_MUL;
        else state_nxt = S_BOT;
      end
      S_BOT: begin
        if (y0_r > YL) state_nxt = S_IDLE;
        else if (y1_r > YL) state_nxt = S_MUL;
        else state_nxt = S_XSW;
      end
      S_XSW: state_nxt = S_LEFT;
      S_LEFT: begin
        if (x1_r < 0) state_nxt = S_IDLE;
        else if (x0_r < 0) state_nxt = S_MUL;
        else state_nxt = S_RIGHT;
      end
      S_RIGHT: begin
        if (x0_r > XL) state_nxt = S_OUT;
        else if (x1_r > XL) state_nxt = S_MUL;
        else state_nxt = S_LINE;
      end
      S_MUL: state_nxt = S_DST;
      S_DST: state_nxt = S_DWT;
      S_DWT: begin
        if (div_done) begin
          unique case (cross_r)
            CR_TOP:   state_nxt = S_BOT;
            CR_BOT:   state_nxt = S_XSW;
            CR_LEFT:  state_nxt = S_RIGHT;
            CR_RIGHT: state_nxt = S_LINE;
            default:  state_nxt = S_LINE;
          endcase
        end
      end
      S_LINE: begin
        if ((outside_r == 3'd0 || hit_r) && uy0 != uy1)
          state_nxt = l_ok ? S_LSET : S_OUT;
        else state_nxt = S_OUT;
      end
      S_LSET: state_nxt = S_OUT;
      S_OUT: begin
        if (cnt_r == 2'd0) state_nxt = S_IDLE;
        else if (ld && (idx_r == 1'b1 || cnt_r == 2'd1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop = (state_r == S_IDLE) && q_valid;
    div_start = (state_r == S_DST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_lo_r <= YL;
      span_hi_r <= '0;
      cnt_r <= 2'd0;
      idx_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.op == OP_RESET) begin
              span_lo_r <= YL;
              span_hi_r <= '0;
            end
            x0_r <= q_item.x0;
            y0_r <= q_item.y0;
            x1_r <= q_item.x1;
            y1_r <= q_item.y1;
            outside_r <= 3'd4;
            hit_r <= 1'b0;
            cnt_r <= 2'd0;
            idx_r <= 1'b0;
          end
        end
        S_TOP: begin
          cross_r <= CR_TOP;
          c_r <= y0_r;
          n_r <= x1_r - x0_r;
          d_r <= y1_r - y0_r;
          if (!(y0_r < 0)) outside_r <= outside_r - 3'd1;
        end
        S_BOT: begin
          cross_r <= CR_BOT;
          c_r <= YL - y1_r;
          n_r <= x1_r - x0_r;
          d_r <= y1_r - y0_r;
          if (!(y1_r > YL)) outside_r <= outside_r - 3'd1;
        end
        S_XSW: begin
          if (x0_r > x1_r) begin
            x0_r <= x1_r; x1_r <= x0_r;
            y0_r <= y1_r; y1_r <= y0_r;
          end
        end
        S_LEFT: begin
          cross_r <= CR_LEFT;
          c_r <= x0_r;
          n_r <= y1_r - y0_r;
          d_r <= x1_r - x0_r;
          if (!(x0_r < 0)) outside_r <= outside_r - 3'd1;
        end
        S_RIGHT: begin
          cross_r <= CR_RIGHT;
          c_r <= XL - x1_r;
          n_r <= y1_r - y0_r;
          d_r <= x1_r - x0_r;
          if (x0_r > XL) begin
            if (f_ok) begin
              desc_r[cnt_r[0]] <= f_desc;
              cnt_r <= cnt_r + 2'd1;
              span_lo_r <= f_nlo;
              span_hi_r <= f_nhi;
            end
          end else if (!(x1_r > XL)) outside_r <= outside_r - 3'd1;
        end
        S_MUL: prod_r <= c_r * n_r;
        S_DST: ;
        S_DWT: begin
          if (div_done) begin
            unique case (cross_r)
              CR_TOP: if (v_top >= 0 && v_top <= XL) begin
                x0_r <= v_top; y0_r <= '0; hit_r <= 1'b1;
              end
              CR_BOT: if (v_bot >= 0 && v_bot <= XL) begin
                x1_r <= v_bot; y1_r <= YL; hit_r <= 1'b1;
              end
              CR_LEFT: if (v_left >= 0 && v_left <= YL) begin
                x0_r <= '0; y0_r <= v_left; hit_r <= 1'b1;
              end
              CR_RIGHT: begin
                if (f_ok) begin
                  desc_r[cnt_r[0]] <= f_desc;
                  cnt_r <= cnt_r + 2'd1;
                  span_lo_r <= f_nlo;
                  span_hi_r <= f_nhi;
                end
                if (v_right >= 0 && v_right <= YL) begin
                  x1_r <= XL; y1_r <= v_right; hit_r <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_LINE: begin
          lx_r <= ux0;
          ly_r <= uy0;
          ed_r <= l_ed;
          sd_r <= l_sd;
          if ((outside_r == 3'd0 || hit_r) && uy0 != uy1) begin
            span_lo_r <= l_nlo;
            span_hi_r <= l_nhi;
          end
        end
        S_LSET: begin
          desc_r[cnt_r[0]] <= l_desc;
          cnt_r <= cnt_r + 2'd1;
        end
        S_OUT: begin
          if (ld) idx_r <= !idx_r;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ld) begin
      out_desc_r <= desc_r[idx_r];
      out_last_r <= (idx_r == 1'b1) || (cnt_r == 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ld) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_desc = out_desc_r;
  assign out_last = out_last_r;

endmodule

// File: src/clipped_xor_fill_edge_setup.sv
// top level of the clipped xor-fill edge setup block
// Each edge item is clipped to the viewport 0..X_LIMIT by 0..Y_LIMIT and gives
// up to two descriptors: a right-column fill fixup first, then a one-dot line,
// with last set on the final one; a reset item restarts the seed row span and
// gives none. Every viewport side an edge item crosses costs one edge
// crossing on the single shared 31-step serial divider, which sets the rate;
// line setup and descriptor output add to the time per item. A two-entry
// queue in front keeps accepting items while the divider works, until both
// entries are full, and the result register holds a descriptor while the
// next one forms.
module clipped_xor_fill_edge_setup import cxf_pkg::*; #(
  parameter int X_LIMIT = 319,
  parameter int Y_LIMIT = 199
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic signed [CW-1:0] in_ax,
  input  logic signed [CW-1:0] in_ay,
  input  logic signed [CW-1:0] in_bx,
  input  logic signed [CW-1:0] in_by,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [CW-1:0]        out_start_x,
  output logic [CW-1:0]        out_start_y,
  output logic [1:0]           out_octant,
  output logic                 out_sign_init,
  output logic signed [CW-1:0] out_err_init,
  output logic signed [CW-1:0] out_a_mod,
  output logic [14:0]          out_b_mod,
  output logic [9:0]           out_run_length,
  output logic                 out_last,
  output logic signed [CW-1:0] out_seed_low,
  output logic signed [CW-1:0] out_seed_high
);

  logic  q_valid, q_pop;
  item_t q_item;
  desc_t desc;

  cxf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op   (in_op),
    .in_ax   (in_ax),
    .in_ay   (in_ay),
    .in_bx   (in_bx),
    .in_by   (in_by),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  cxf_back #(
    .X_LIMIT(X_LIMIT),
    .Y_LIMIT(Y_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_desc (desc),
    .out_last (out_last)
  );

  assign out_kind = desc.kind;
  assign out_start_x = desc.start_x;
  assign out_start_y = desc.start_y;
  assign out_octant = desc.octant;
  assign out_sign_init = desc.sign_init;
  assign out_err_init = desc.err_init;
  assign out_a_mod = desc.a_mod;
  assign out_b_mod = desc.b_mod;
  assign out_run_length = desc.run_length;
  assign out_seed_low = desc.seed_low;
  assign out_seed_high = desc.seed_high;

endmodule
